>>> hw/rtl/rotate_point_about_center_core_assert.svh
// Assertion helpers for the rotate-about-center pipeline.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ROTATE_POINT_ABOUT_CENTER_CORE_ASSERT_SVH
`define ROTATE_POINT_ABOUT_CENTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RPAC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rpac_pkg.sv
package rpac_pkg;

  // CORDIC iteration count; the arctangent table has MAX_STAGES entries
  localparam int ITERATIONS  = 16;
  localparam int MAX_STAGES  = 24;
  localparam int NUM_STAGES  = (ITERATIONS < MAX_STAGES) ? ITERATIONS : MAX_STAGES;
  localparam int STAGE_IDX_W = 5;

  // coordinate and working widths
  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int ANGLE_W    = 16;
  localparam int QTR_W      = ANGLE_W - 2;
  localparam int Z_SHIFT    = 32 - ANGLE_W;
  localparam int Z_W        = 34;
  localparam int ATAN_W     = 30;
  localparam int GAIN_W     = 31;
  localparam int PROD_W     = DIFF_W + GAIN_W;
  localparam int GAIN_SHIFT = 14;
  localparam int GUARD      = 16;
  localparam int WORK_W     = 44;
  localparam int RES_W      = WORK_W - GUARD;
  localparam int SUM_W      = RES_W + 1;

  localparam logic [ANGLE_W-1:0]       HALF_QTR   = ANGLE_W'(1 << (QTR_W - 1));
  localparam logic signed [GAIN_W-1:0] GAIN_Q30   = 31'sh26DD3B6A;
  localparam logic signed [PROD_W-1:0] ROUND_GAIN = PROD_W'(1) << (GAIN_SHIFT - 1);
  localparam logic signed [WORK_W-1:0] ROUND_OUT  = WORK_W'(1) << (GUARD - 1);

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

  // whole quarter turns applied ahead of the CORDIC
  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_e;

  typedef struct packed {
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    quad_e                     quad;
    logic signed [Z_W-1:0]     z;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } diff_t;

  typedef struct packed {
    logic signed [PROD_W-1:0]  px;
    logic signed [PROD_W-1:0]  py;
    logic signed [Z_W-1:0]     z;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } prod_t;

  typedef struct packed {
    logic signed [WORK_W-1:0]  wx;
    logic signed [WORK_W-1:0]  wy;
    logic signed [Z_W-1:0]     z;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } work_t;

  typedef struct packed {
    logic signed [RES_W-1:0]   rx;
    logic signed [RES_W-1:0]   ry;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } res_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [ATAN_W-1:0] atan_turn(input logic [STAGE_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 30'h20000000;
      5'd1:    val = 30'h12E4051E;
      5'd2:    val = 30'h09FB385B;
      5'd3:    val = 30'h051111D4;
      5'd4:    val = 30'h028B0D43;
      5'd5:    val = 30'h0145D7E1;
      5'd6:    val = 30'h00A2F61E;
      5'd7:    val = 30'h00517C55;
      5'd8:    val = 30'h0028BE53;
      5'd9:    val = 30'h00145F2F;
      5'd10:   val = 30'h000A2F98;
      5'd11:   val = 30'h000517CC;
      5'd12:   val = 30'h00028BE6;
      5'd13:   val = 30'h000145F3;
      5'd14:   val = 30'h0000A2FA;
      5'd15:   val = 30'h0000517D;
      5'd16:   val = 30'h000028BE;
      5'd17:   val = 30'h0000145F;
      5'd18:   val = 30'h00000A30;
      5'd19:   val = 30'h00000518;
      5'd20:   val = 30'h0000028C;
      5'd21:   val = 30'h00000146;
      5'd22:   val = 30'h000000A3;
      5'd23:   val = 30'h00000051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> hw/rtl/rotate_point_about_center_core.sv
// Depth: 6 + ITERATIONS register stages (22 at 16 iterations).
// Throughput: one point per cycle; the unrolled CORDIC chain has one register stage per
// iteration, so every stage takes a new item each cycle while the output is free.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; payload is not reset.
`include "rotate_point_about_center_core_assert.svh"

module rotate_point_about_center_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic signed [rpac_pkg::COORD_W-1:0] x_in_i,
  input  logic signed [rpac_pkg::COORD_W-1:0] y_in_i,
  input  logic [rpac_pkg::ANGLE_W-1:0]        angle_i,
  input  logic signed [rpac_pkg::COORD_W-1:0] center_x_i,
  input  logic signed [rpac_pkg::COORD_W-1:0] center_y_i,
  // result channel
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic signed [rpac_pkg::COORD_W-1:0] x_out_o,
  output logic signed [rpac_pkg::COORD_W-1:0] y_out_o
);

  // Pipeline overview:
  //   prep   (4 stages): subtract the center, split the angle into whole quarter turns
  //                      and a residual within one eighth turn, apply the quarter turns
  //                      by swap and negate, multiply by the CORDIC gain, round half up.
  //   cordic (ITERATIONS stages): one shift-add micro-rotation per stage.
  //   post   (2 stages): round off the guard bits, add the center, saturate.
  // Every stage carries its own valid bit. A stage holds only when it is full and
  // the stage after it holds, so bubbles collapse and the input keeps taking
  // transfers while a finished result waits at the output register.

  logic            prep_valid, prep_stall;
  logic            cord_valid, cord_stall;
  rpac_pkg::work_t prep_data, cord_data;

  rpac_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .x_in_i     (x_in_i),
    .y_in_i     (y_in_i),
    .angle_i    (angle_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .valid_o    (prep_valid),
    .stall_i    (prep_stall),
    .data_o     (prep_data)
  );

  rpac_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .stall_o (prep_stall),
    .data_i  (prep_data),
    .valid_o (cord_valid),
    .stall_i (cord_stall),
    .data_o  (cord_data)
  );

  rpac_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cord_valid),
    .stall_o (cord_stall),
    .data_i  (cord_data),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .x_out_o (x_out_o),
    .y_out_o (y_out_o)
  );

  // Hold at the input only when the whole chain is full behind a held result.
  `RPAC_ASSERT_IMPL(a_in_hold_full, stall_o, valid_o && stall_i, "input held with room in pipe")
  // The CORDIC chain pushes back on prep only when it is full and post holds.
  `RPAC_ASSERT_IMPL(a_cordic_hold, prep_stall, cord_valid && cord_stall, "cordic hold without cause")
  // Post pushes back only while the output transfer is held.
  `RPAC_ASSERT_IMPL(a_post_hold, cord_stall, valid_o && stall_i, "post hold without cause")

endmodule

>>> hw/rtl/rpac_prep.sv
`include "rotate_point_about_center_core_assert.svh"

module rpac_prep (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic signed [rpac_pkg::COORD_W-1:0] x_in_i,
  input  logic signed [rpac_pkg::COORD_W-1:0] y_in_i,
  input  logic [rpac_pkg::ANGLE_W-1:0]        angle_i,
  input  logic signed [rpac_pkg::COORD_W-1:0] center_x_i,
  input  logic signed [rpac_pkg::COORD_W-1:0] center_y_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output rpac_pkg::work_t                    data_o
);

  logic [3:0] v_q;
  logic [3:0] up_stall;

  rpac_pkg::diff_t s1_d, s1_q;
  rpac_pkg::diff_t s2_d, s2_q;
  rpac_pkg::prod_t s3_d, s3_q;
  rpac_pkg::work_t s4_d, s4_q;

  logic [rpac_pkg::ANGLE_W-1:0]      ang_sum;
  logic signed [rpac_pkg::QTR_W-1:0] resid;
  logic signed [rpac_pkg::PROD_W-1:0] rnd_x, rnd_y;
  logic signed [rpac_pkg::PROD_W-1:0] shf_x, shf_y;

  // a stage holds when it is full and the one after it holds
  assign up_stall[3] = v_q[3] & stall_i;
  assign up_stall[2] = v_q[2] & up_stall[3];
  assign up_stall[1] = v_q[1] & up_stall[2];
  assign up_stall[0] = v_q[0] & up_stall[1];
  assign stall_o     = up_stall[0];

  // stage 1: difference vector, quadrant and residual angle
  always_comb begin
    ang_sum    = angle_i + rpac_pkg::HALF_QTR;
    resid      = {~ang_sum[rpac_pkg::QTR_W-1], ang_sum[rpac_pkg::QTR_W-2:0]};
    s1_d.dx    = rpac_pkg::DIFF_W'(x_in_i) - rpac_pkg::DIFF_W'(center_x_i);
    s1_d.dy    = rpac_pkg::DIFF_W'(y_in_i) - rpac_pkg::DIFF_W'(center_y_i);
    s1_d.quad  = rpac_pkg::quad_e'(ang_sum[rpac_pkg::ANGLE_W-1:rpac_pkg::QTR_W]);
    s1_d.z     = rpac_pkg::Z_W'($signed({resid, {rpac_pkg::Z_SHIFT{1'b0}}}));
    s1_d.cx    = center_x_i;
    s1_d.cy    = center_y_i;
  end

  // stage 2: apply whole quarter turns exactly
  always_comb begin
    s2_d = s1_q;
    case (s1_q.quad)
      rpac_pkg::QUAD_90: begin
        s2_d.dx = -s1_q.dy;
        s2_d.dy = s1_q.dx;
      end
      rpac_pkg::QUAD_180: begin
        s2_d.dx = -s1_q.dx;
        s2_d.dy = -s1_q.dy;
      end
      rpac_pkg::QUAD_270: begin
        s2_d.dx = s1_q.dy;
        s2_d.dy = -s1_q.dx;
      end
      default: begin
      end
    endcase
  end

  // stage 3: gain compensation product
  always_comb begin
    s3_d.px = rpac_pkg::PROD_W'($signed(s2_q.dx)) * rpac_pkg::PROD_W'(rpac_pkg::GAIN_Q30);
    s3_d.py = rpac_pkg::PROD_W'($signed(s2_q.dy)) * rpac_pkg::PROD_W'(rpac_pkg::GAIN_Q30);
    s3_d.z  = s2_q.z;
    s3_d.cx = s2_q.cx;
    s3_d.cy = s2_q.cy;
  end

  // stage 4: round half up to the working format
  always_comb begin
    rnd_x   = $signed(s3_q.px) + rpac_pkg::ROUND_GAIN;
    rnd_y   = $signed(s3_q.py) + rpac_pkg::ROUND_GAIN;
    shf_x   = rnd_x >>> rpac_pkg::GAIN_SHIFT;
    shf_y   = rnd_y >>> rpac_pkg::GAIN_SHIFT;
    s4_d.wx = shf_x[rpac_pkg::WORK_W-1:0];
    s4_d.wy = shf_y[rpac_pkg::WORK_W-1:0];
    s4_d.z  = s3_q.z;
    s4_d.cx = s3_q.cx;
    s4_d.cy = s3_q.cy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (!up_stall[0]) v_q[0] <= valid_i;
      if (!up_stall[1]) v_q[1] <= v_q[0];
      if (!up_stall[2]) v_q[2] <= v_q[1];
      if (!up_stall[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!up_stall[0]) s1_q <= s1_d;
    if (!up_stall[1]) s2_q <= s2_d;
    if (!up_stall[2]) s3_q <= s3_d;
    if (!up_stall[3]) s4_q <= s4_d;
  end

  assign valid_o = v_q[3];
  assign data_o  = s4_q;

  `RPAC_ASSERT_NEXT(a_accept_loads, valid_i && !stall_o, v_q[0], "accepted item not captured")

endmodule

>>> hw/rtl/rpac_cordic.sv
module rpac_cordic (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  rpac_pkg::work_t data_i,
  output logic            valid_o,
  input  logic            stall_i,
  output rpac_pkg::work_t data_o
);

  localparam int N = rpac_pkg::NUM_STAGES;

  logic [N-1:0]    v_q;
  logic [N-1:0]    up_stall;
  rpac_pkg::work_t d_q [N];
  rpac_pkg::work_t nxt [N];

  for (genvar i = 0; i < N; i++) begin : g_iter
    rpac_pkg::work_t                  src;
    logic                             down_stall;
    logic signed [rpac_pkg::WORK_W-1:0] sx, sy, nx, ny;
    logic signed [rpac_pkg::Z_W-1:0]    nz, ang;

    if (i == 0) begin : g_first
      assign src = data_i;
    end else begin : g_next
      assign src = d_q[i-1];
    end

    if (i == N - 1) begin : g_last
      assign down_stall = stall_i;
    end else begin : g_mid
      assign down_stall = up_stall[i+1];
    end

    assign up_stall[i] = v_q[i] & down_stall;

    // one micro-rotation: shift by i, direction from the residual's sign
    assign ang = rpac_pkg::Z_W'(rpac_pkg::atan_turn(rpac_pkg::STAGE_IDX_W'(i)));
    assign sx  = $signed(src.wx) >>> i;
    assign sy  = $signed(src.wy) >>> i;
    assign nx  = src.z[rpac_pkg::Z_W-1] ? src.wx + sy : src.wx - sy;
    assign ny  = src.z[rpac_pkg::Z_W-1] ? src.wy - sx : src.wy + sx;
    assign nz  = src.z[rpac_pkg::Z_W-1] ? src.z + ang : src.z - ang;
    assign nxt[i] = {nx, ny, nz, src.cx, src.cy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (!up_stall[k]) v_q[k] <= (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (!up_stall[k]) d_q[k] <= nxt[k];
    end
  end

  assign stall_o = up_stall[0];
  assign valid_o = v_q[N-1];
  assign data_o  = d_q[N-1];

endmodule

>>> hw/rtl/rpac_post.sv
module rpac_post (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  rpac_pkg::work_t                    data_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic signed [rpac_pkg::COORD_W-1:0] x_out_o,
  output logic signed [rpac_pkg::COORD_W-1:0] y_out_o
);

  logic [1:0] v_q;
  logic [1:0] up_stall;

  rpac_pkg::res_t res_d, res_q;
  logic signed [rpac_pkg::WORK_W-1:0] rnd_x, rnd_y, shf_x, shf_y;
  logic signed [rpac_pkg::SUM_W-1:0]  sum_x, sum_y;
  logic [rpac_pkg::COORD_W-1:0]       x_d, y_d, x_q, y_q;

  function automatic logic [rpac_pkg::COORD_W-1:0] sat(
    input logic [rpac_pkg::SUM_W-1:0] v
  );
    logic [rpac_pkg::SUM_W-rpac_pkg::COORD_W:0] top;
    top = v[rpac_pkg::SUM_W-1:rpac_pkg::COORD_W-1];
    if ((&top) || !(|top)) begin
      return v[rpac_pkg::COORD_W-1:0];
    end
    return v[rpac_pkg::SUM_W-1] ? rpac_pkg::COORD_MIN : rpac_pkg::COORD_MAX;
  endfunction

  assign up_stall[1] = v_q[1] & stall_i;
  assign up_stall[0] = v_q[0] & up_stall[1];
  assign stall_o     = up_stall[0];

  // drop the guard bits with round-half-up
  always_comb begin
    rnd_x    = $signed(data_i.wx) + rpac_pkg::ROUND_OUT;
    rnd_y    = $signed(data_i.wy) + rpac_pkg::ROUND_OUT;
    shf_x    = rnd_x >>> rpac_pkg::GUARD;
    shf_y    = rnd_y >>> rpac_pkg::GUARD;
    res_d.rx = shf_x[rpac_pkg::RES_W-1:0];
    res_d.ry = shf_y[rpac_pkg::RES_W-1:0];
    res_d.cx = data_i.cx;
    res_d.cy = data_i.cy;
  end

  // add the center back and clamp to the coordinate range
  always_comb begin
    sum_x = rpac_pkg::SUM_W'($signed(res_q.cx)) + rpac_pkg::SUM_W'($signed(res_q.rx));
    sum_y = rpac_pkg::SUM_W'($signed(res_q.cy)) + rpac_pkg::SUM_W'($signed(res_q.ry));
    x_d   = sat(sum_x);
    y_d   = sat(sum_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (!up_stall[0]) v_q[0] <= valid_i;
      if (!up_stall[1]) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!up_stall[0]) res_q <= res_d;
    if (!up_stall[1]) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign valid_o = v_q[1];
  assign x_out_o = x_q;
  assign y_out_o = y_q;

endmodule

>>> dv/rotate_point_about_center_core_test.sv
module rotate_point_about_center_core_test;

  // pipeline depth in register stages
  localparam int LATENCY     = 6 + rpac_pkg::ITERATIONS;
  // the last stretch of the run goes without idling on either side
  localparam int CALM_ITEMS  = 120;
  localparam int RAND_ITEMS  = 1080;
  localparam longint TIMEOUT = 64'd3_000_000;

  // CORDIC gain compensation, Q0.30
  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint COORD_HI    = 64'sd8388607;
  localparam longint COORD_LO    = -64'sd8388608;
  localparam int     ATAN_BITS_W = 30;
  localparam int     ATAN_COUNT  = 24;

  // arctangent of 2^-i in units of 2^-32 turn, entry 0 in the top slot
  localparam logic [ATAN_COUNT*ATAN_BITS_W-1:0] ATAN_BITS = {
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
    30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
    30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D,
    30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

  typedef struct {
    logic signed [rpac_pkg::COORD_W-1:0] px;
    logic signed [rpac_pkg::COORD_W-1:0] py;
    logic [rpac_pkg::ANGLE_W-1:0]        ang;
    logic signed [rpac_pkg::COORD_W-1:0] cx;
    logic signed [rpac_pkg::COORD_W-1:0] cy;
    bit                                  drain;  // wait for an empty pipe first
  } point_req_t;

  typedef struct {
    logic signed [rpac_pkg::COORD_W-1:0] rx;
    logic signed [rpac_pkg::COORD_W-1:0] ry;
  } rot_pair_t;

  logic                                clk_i      = 1'b0;
  logic                                rst_ni     = 1'b0;
  logic                                valid_i    = 1'b0;
  logic                                stall_o;
  logic signed [rpac_pkg::COORD_W-1:0] x_in_i     = '0;
  logic signed [rpac_pkg::COORD_W-1:0] y_in_i     = '0;
  logic [rpac_pkg::ANGLE_W-1:0]        angle_i    = '0;
  logic signed [rpac_pkg::COORD_W-1:0] center_x_i = '0;
  logic signed [rpac_pkg::COORD_W-1:0] center_y_i = '0;
  logic                                valid_o;
  logic                                stall_i    = 1'b0;
  logic signed [rpac_pkg::COORD_W-1:0] x_out_o;
  logic signed [rpac_pkg::COORD_W-1:0] y_out_o;

  point_req_t points_q[$];   // stimulus not yet handed to the block
  rot_pair_t  rotated_q[$];  // rotated points still owed by the block

  logic in_xfer   = 1'b0;    // input transfer seen at the last rising edge
  int   gap_left  = 0;
  int   stall_left = 0;
  int   total_items = 0;
  int   accepted_cnt = 0;
  int   mismatch_cnt = 0;

  rotate_point_about_center_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .x_in_i     (x_in_i),
    .y_in_i     (y_in_i),
    .angle_i    (angle_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .x_out_o    (x_out_o),
    .y_out_o    (y_out_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic logic signed [rpac_pkg::COORD_W-1:0] clamp_coord(input longint v);
    if (v > COORD_HI) begin
      return COORD_HI[rpac_pkg::COORD_W-1:0];
    end else if (v < COORD_LO) begin
      return COORD_LO[rpac_pkg::COORD_W-1:0];
    end
    return v[rpac_pkg::COORD_W-1:0];
  endfunction

  // Rotate the point about the center: exact quarter turns first, then the
  // CORDIC handles the residual angle in [-1/8, 1/8) turn.
  function automatic rot_pair_t rotate_about(input point_req_t p);
    rot_pair_t res;
    longint dx, dy, t, wx, wy, sx, sy, z, quarters, rx, ry;
    dx = longint'($signed(p.px)) - longint'($signed(p.cx));
    dy = longint'($signed(p.py)) - longint'($signed(p.cy));
    quarters = (longint'(p.ang) + 64'sd8192) >>> 14;
    // residual angle scaled to 2^-32 turn
    z = (longint'(p.ang) - quarters * 64'sd16384) * 64'sd65536;
    case (rpac_pkg::quad_e'(quarters[1:0]))
      rpac_pkg::QUAD_90: begin
        t = dx; dx = -dy; dy = t;
      end
      rpac_pkg::QUAD_180: begin
        dx = -dx; dy = -dy;
      end
      rpac_pkg::QUAD_270: begin
        t = dx; dx = dy; dy = -t;
      end
      default: ;
    endcase
    // apply the gain up front, keep 16 guard bits
    wx = (dx * CORDIC_GAIN + 64'sd8192) >>> 14;
    wy = (dy * CORDIC_GAIN + 64'sd8192) >>> 14;
    for (int i = 0; i < rpac_pkg::ITERATIONS && i < ATAN_COUNT; i++) begin
      sx = wx >>> i;
      sy = wy >>> i;
      if (z >= 0) begin
        wx = wx - sy;
        wy = wy + sx;
        z  = z - longint'(ATAN_BITS[(ATAN_COUNT-1-i)*ATAN_BITS_W +: ATAN_BITS_W]);
      end else begin
        wx = wx + sy;
        wy = wy - sx;
        z  = z + longint'(ATAN_BITS[(ATAN_COUNT-1-i)*ATAN_BITS_W +: ATAN_BITS_W]);
      end
    end
    // drop guard bits with round-half-up, move back to the center, clamp
    rx = (wx + 64'sd32768) >>> 16;
    ry = (wy + 64'sd32768) >>> 16;
    res.rx = clamp_coord(longint'($signed(p.cx)) + rx);
    res.ry = clamp_coord(longint'($signed(p.cy)) + ry);
    return res;
  endfunction

  // Driver: change inputs on the falling edge only. Advance to a new point
  // once the current one has transferred; hold the payload while stalled.
  always @(negedge clk_i) begin
    point_req_t nxt;
    bit calm;
    calm = points_q.size() < CALM_ITEMS;
    if (rst_ni) begin
      if (!valid_i || in_xfer) begin
        if (gap_left != 0) begin
          // idle burst on the input side
          valid_i  <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (points_q.size() != 0 &&
                     !(points_q[0].drain && rotated_q.size() != 0)) begin
          nxt = points_q.pop_front();
          x_in_i     <= nxt.px;
          y_in_i     <= nxt.py;
          angle_i    <= nxt.ang;
          center_x_i <= nxt.cx;
          center_y_i <= nxt.cy;
          valid_i    <= 1'b1;
          // schedule an idle burst right after this transfer now and then
          if (!calm && $urandom_range(0, 9) == 0) begin
            gap_left <= $urandom_range(1, 19);
          end
        end else begin
          // nothing to send, or waiting for the pipe to drain
          valid_i <= 1'b0;
        end
      end

      // result side back-pressure in bursts of random length
      if (stall_left != 0) begin
        stall_i    <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_i    <= 1'b1;
        stall_left <= $urandom_range(0, 18);
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // Monitor: sample both channels on the rising edge. Check the result side
  // before recording a new input so the order within the edge never matters.
  always @(posedge clk_i) begin
    rot_pair_t want;
    point_req_t seen;
    if (!rst_ni) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= valid_i && !stall_o;

      if (valid_o && !stall_i) begin
        if (rotated_q.size() == 0) begin
          report_mismatch($sformatf("result x=%0d y=%0d with nothing outstanding",
                                    x_out_o, y_out_o));
        end else begin
          want = rotated_q.pop_front();
          if (x_out_o !== want.rx) begin
            report_mismatch($sformatf("x_out expected %0d, got %0d", want.rx, x_out_o));
          end
          if (y_out_o !== want.ry) begin
            report_mismatch($sformatf("y_out expected %0d, got %0d", want.ry, y_out_o));
          end
        end
      end

      if (valid_i && !stall_o) begin
        seen.px    = x_in_i;
        seen.py    = y_in_i;
        seen.ang   = angle_i;
        seen.cx    = center_x_i;
        seen.cy    = center_y_i;
        seen.drain = 1'b0;
        rotated_q.push_back(rotate_about(seen));
        accepted_cnt++;
      end
    end
  end

  task automatic add_point(input longint px, input longint py, input int ang,
                           input longint cx, input longint cy, input bit drain);
    point_req_t p;
    p.px    = px[rpac_pkg::COORD_W-1:0];
    p.py    = py[rpac_pkg::COORD_W-1:0];
    p.ang   = ang[rpac_pkg::ANGLE_W-1:0];
    p.cx    = cx[rpac_pkg::COORD_W-1:0];
    p.cy    = cy[rpac_pkg::COORD_W-1:0];
    p.drain = drain;
    points_q.push_back(p);
    total_items++;
  endtask

  // Pick a coordinate: mostly moderate magnitudes, some full range, some at
  // the limits so the output clamps get exercised.
  function automatic longint pick_coord();
    case ($urandom_range(0, 7))
      0, 1:    return longint'($signed(24'($urandom())));
      2:       return ($urandom_range(0, 1) != 0) ? COORD_HI - $urandom_range(0, 255)
                                                  : COORD_LO + $urandom_range(0, 255);
      3, 4:    return longint'($urandom_range(0, 524287)) - 64'sd262144;
      default: return longint'($urandom_range(0, 16383)) - 64'sd8192;
    endcase
  endfunction

  function automatic int pick_angle();
    // a quarter of the angles sit within two steps of a 1/8-turn boundary
    if ($urandom_range(0, 3) == 0) begin
      return (int'($urandom_range(0, 7)) * 8192 + int'($urandom_range(0, 4)) - 2) & 16'hFFFF;
    end
    return $urandom_range(0, 65535);
  endfunction

  initial begin
    // directed points: zero input, every quarter turn, the 1/8-turn split
    // points, coordinate extremes and clamping in both directions
    add_point(0, 0, 0, 0, 0, 1'b0);
    add_point(25600, 12800, 16'h0000, 0, 0, 1'b0);
    add_point(25600, 12800, 16'h4000, 0, 0, 1'b0);
    add_point(25600, 12800, 16'h8000, 0, 0, 1'b0);
    add_point(25600, 12800, 16'hC000, 0, 0, 1'b0);
    add_point(25600, -12800, 16'h1FFF, 512, -768, 1'b0);
    add_point(25600, -12800, 16'h2000, 512, -768, 1'b0);
    add_point(-7000, 3000, 16'hDFFF, -256, 1024, 1'b0);
    add_point(-7000, 3000, 16'hE000, -256, 1024, 1'b0);
    add_point(-7000, 3000, 16'hFFFF, -256, 1024, 1'b0);
    add_point(1000, 2000, 16'h1000, 3000, 4000, 1'b0);
    add_point(COORD_HI, COORD_LO, 16'h0000, 0, 0, 1'b0);
    add_point(COORD_LO, COORD_HI, 16'h0000, 0, 0, 1'b0);
    // point and center at opposite limits: a half turn clamps low, then high
    add_point(COORD_HI, 0, 16'h8000, COORD_LO, 0, 1'b0);
    add_point(COORD_LO, 0, 16'h8000, COORD_HI, 0, 1'b0);
    add_point(0, COORD_HI, 16'h8000, 0, COORD_LO, 1'b0);
    add_point(0, COORD_LO, 16'h8000, 0, COORD_HI, 1'b0);
    add_point(COORD_HI, COORD_HI, 16'h4000, COORD_LO, COORD_LO, 1'b0);
    add_point(COORD_LO, COORD_LO, 16'hC000, COORD_HI, COORD_HI, 1'b0);
    add_point(0, 0, 16'h6000, COORD_HI, COORD_LO, 1'b0);
    add_point(COORD_HI, COORD_HI, 16'hFFFF, COORD_HI, COORD_HI, 1'b0);
    add_point(-1, -1, 16'h2001, 1, 1, 1'b1);

    // random points, drain the pipe now and then before sending the next
    for (int n = 0; n < RAND_ITEMS; n++) begin
      add_point(pick_coord(), pick_coord(), pick_angle(), pick_coord(), pick_coord(),
                (n % 350) == 349);
    end

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_cnt == total_items);
    wait (rotated_q.size() == 0);
    // let any stray result show up before closing
    repeat (LATENCY + 16) @(posedge clk_i);
    if (rotated_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", rotated_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("timeout: %0d of %0d points accepted, %0d results outstanding",
             accepted_cnt, total_items, rotated_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
